FILE: sv/ptq_pkg.sv
// Package for the periodic timer queue: sizes, word formats, result codes
// and the per-slot timer record. No dependencies.
`default_nettype none
package ptq_pkg;
	localparam int SLOTS     = 16;
	localparam int TIME_BITS = 32;
	localparam int ID_BITS   = 16;
	localparam int IDX_BITS  = $clog2(SLOTS);
	localparam int OCC_BITS  = $clog2(SLOTS + 1);
	localparam logic [16:0] FOREVER = 17'h10000;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_ADD  = 2'd1,
		KIND_DEL  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		EV_FIRED    = 3'd0,
		EV_ADDED    = 3'd1,
		EV_REJECTED = 3'd2,
		EV_DELETED  = 3'd3,
		EV_NOTFOUND = 3'd4
	} event_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] period;
		logic [15:0] repeat_count;
		logic [31:0] user_tag;
		logic [15:0] target_id;
	} in_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [15:0] tid;
		logic [31:0] tag_out;
		logic        last;
	} out_t;

	typedef struct packed {
		logic                 vld;
		logic [15:0]          per;
		logic [TIME_BITS-1:0] dl;
		logic [16:0]          rem;
		logic [ID_BITS-1:0]   id;
		logic [31:0]          tag;
	} rec_t;

	typedef struct packed {
		logic rot;
		logic sqz;
		logic load;
	} cell_ctl_t;
endpackage
`default_nettype wire

FILE: sv/ptq_cell.sv
// One slot of the timer chain: holds a timer record, rotates, squeezes out
// holes and takes a new record. Depends on ptq_pkg.
`default_nettype none
module ptq_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ptq_pkg::cell_ctl_t       ctl,
	input  wire logic [ptq_pkg::OCC_BITS-1:0] my_idx,
	input  wire logic [ptq_pkg::OCC_BITS-1:0] ld_idx,
	input  wire ptq_pkg::rec_t            ld_rec,
	input  wire ptq_pkg::rec_t            nxt_rec,
	input  wire logic                     hole_in,
	output logic                          hole_out,
	output ptq_pkg::rec_t                 rec
);
	ptq_pkg::rec_t rec_q;

	assign rec      = rec_q;
	assign hole_out = hole_in | ~rec_q.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q.vld <= 1'b0;
		end else if (ctl.rot) begin
			rec_q <= nxt_rec;
		end else if (ctl.sqz) begin
			if (hole_out) rec_q <= nxt_rec;
		end else if (ctl.load && my_idx == ld_idx) begin
			rec_q <= ld_rec;
		end
	end
endmodule
`default_nettype wire

FILE: sv/periodic_timer_queue.sv
// Top level of the periodic timer queue: chain of timer cells plus the
// head engine and output register. Depends on ptq_pkg and ptq_cell.
//
// Timers live in a chain of SLOTS cells in age order. An add is accepted,
// then the result register loads. An unused kind is taken and gives nothing.
// A delete rotates the whole chain once past the head engine and then answers.
// A tick rotates the chain once, checking one timer per cycle at the head
// while no fire is held up by a full output, then squeezes out finished
// timers in a second pass over the chain.
// Every item waits further while its final word cannot enter the output.
`default_nettype none
module periodic_timer_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ptq_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ptq_pkg::out_t      out_data
);
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_SQZ,
		ST_DEL,
		ST_FLUSH
	} state_t;

	state_t                         st_q;
	logic [ptq_pkg::IDX_BITS-1:0]   cnt_q;
	logic [ptq_pkg::OCC_BITS-1:0]   occ_q;
	logic [ptq_pkg::TIME_BITS-1:0]  now_q;
	logic [ptq_pkg::ID_BITS-1:0]    nid_q;
	logic [15:0]                    tgt_q;
	logic                           found_q;
	ptq_pkg::out_t                  pend_q;
	logic                           pend_v_q;
	ptq_pkg::out_t                  out_q;
	logic                           out_valid_q;

	ptq_pkg::cell_ctl_t             ctl;
	ptq_pkg::rec_t                  recs [ptq_pkg::SLOTS];
	ptq_pkg::rec_t                  nxts [ptq_pkg::SLOTS];
	logic [ptq_pkg::SLOTS:0]        holes;
	ptq_pkg::rec_t                  ld_rec;
	ptq_pkg::rec_t                  head;
	ptq_pkg::rec_t                  proc_rec;
	ptq_pkg::rec_t                  empty_rec;
	logic [ptq_pkg::TIME_BITS-1:0]  age;
	logic                           drop, due, hit, stall, can_push, acc;
	logic                           pass_end;
	logic                           push;

	assign in_ready  = (st_q == ST_IDLE);
	assign acc       = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign can_push  = ~out_valid_q | out_ready;
	assign pass_end  = (cnt_q == ptq_pkg::IDX_BITS'(ptq_pkg::SLOTS - 1));

	assign head = recs[0];
	assign age  = now_q - head.dl;
	assign drop = (st_q == ST_TICK) && head.vld && (head.rem == 17'd0);
	assign due  = (st_q == ST_TICK) && head.vld && (head.rem != 17'd0)
		&& !age[ptq_pkg::TIME_BITS-1];
	assign hit  = (st_q == ST_DEL) && head.vld && !found_q && (head.id == tgt_q);
	assign stall = due & pend_v_q & ~can_push;
	assign push  = ((st_q == ST_TICK) && due && pend_v_q && can_push)
		|| ((st_q == ST_FLUSH) && pend_v_q && can_push);

	always_comb begin
		proc_rec = head;
		if (drop) proc_rec.vld = 1'b0;
		if (due) begin
			proc_rec.dl = head.dl + ptq_pkg::TIME_BITS'(head.per);
			if (head.rem != ptq_pkg::FOREVER) proc_rec.rem = head.rem - 17'd1;
		end
		if (hit) proc_rec.rem = 17'd0;
		empty_rec     = head;
		empty_rec.vld = 1'b0;
		ld_rec.vld = 1'b1;
		ld_rec.per = in_data.period;
		ld_rec.dl  = now_q + ptq_pkg::TIME_BITS'(in_data.period);
		ld_rec.rem = (in_data.repeat_count == 16'd0) ? ptq_pkg::FOREVER
			: {1'b0, in_data.repeat_count};
		ld_rec.id  = nid_q;
		ld_rec.tag = in_data.user_tag;
	end

	assign ctl.rot  = ((st_q == ST_TICK) && !stall) || (st_q == ST_DEL);
	assign ctl.sqz  = (st_q == ST_SQZ);
	assign ctl.load = acc && (in_data.kind == ptq_pkg::KIND_ADD)
		&& (in_data.period != 16'd0)
		&& (occ_q < ptq_pkg::OCC_BITS'(ptq_pkg::SLOTS));

	assign holes[0] = 1'b0;
	for (genvar i = 0; i < ptq_pkg::SLOTS; i++) begin : g_cell
		if (i == ptq_pkg::SLOTS - 1) begin : g_tail
			assign nxts[i] = ctl.sqz ? empty_rec : proc_rec;
		end else begin : g_mid
			assign nxts[i] = recs[i+1];
		end
		ptq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.my_idx   (ptq_pkg::OCC_BITS'(i)),
			.ld_idx   (occ_q),
			.ld_rec   (ld_rec),
			.nxt_rec  (nxts[i]),
			.hole_in  (holes[i]),
			.hole_out (holes[i+1]),
			.rec      (recs[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			occ_q       <= '0;
			now_q       <= '0;
			nid_q       <= '0;
			tgt_q       <= '0;
			found_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			out_valid_q <= push | (out_valid_q & ~out_ready);
			if (push) begin
				out_q <= '{pend_q.event_res, pend_q.tid, pend_q.tag_out,
					st_q == ST_FLUSH};
			end
			unique case (st_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					tgt_q   <= in_data.target_id;
					if (acc) begin
						unique case (in_data.kind)
							ptq_pkg::KIND_TICK: begin
								now_q <= now_q + ptq_pkg::TIME_BITS'(1);
								st_q  <= ST_TICK;
							end
							ptq_pkg::KIND_ADD: begin
								pend_v_q <= 1'b1;
								st_q     <= ST_FLUSH;
								if (ctl.load) begin
									pend_q <= '{ptq_pkg::EV_ADDED, nid_q, 32'd0, 1'b1};
									occ_q  <= occ_q + ptq_pkg::OCC_BITS'(1);
									nid_q  <= nid_q + ptq_pkg::ID_BITS'(1);
								end else begin
									pend_q <= '{ptq_pkg::EV_REJECTED, 16'd0, 32'd0, 1'b1};
								end
							end
							ptq_pkg::KIND_DEL: st_q <= ST_DEL;
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_TICK: begin
					if (!stall) begin
						cnt_q <= cnt_q + ptq_pkg::IDX_BITS'(1);
						if (drop) occ_q <= occ_q - ptq_pkg::OCC_BITS'(1);
						if (due) begin
							pend_q   <= '{ptq_pkg::EV_FIRED, head.id, head.tag, 1'b1};
							pend_v_q <= 1'b1;
						end
						if (pass_end) st_q <= ST_SQZ;
					end
				end
				ST_SQZ: begin
					cnt_q <= cnt_q + ptq_pkg::IDX_BITS'(1);
					if (pass_end) st_q <= ST_FLUSH;
				end
				ST_DEL: begin
					cnt_q <= cnt_q + ptq_pkg::IDX_BITS'(1);
					if (hit) found_q <= 1'b1;
					if (pass_end) begin
						pend_v_q <= 1'b1;
						pend_q   <= '{(found_q || hit) ? ptq_pkg::EV_DELETED
							: ptq_pkg::EV_NOTFOUND, tgt_q, 32'd0, 1'b1};
						st_q     <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						st_q <= ST_IDLE;
					end else if (can_push) begin
						pend_v_q <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= ptq_pkg::OCC_BITS'(ptq_pkg::SLOTS))
		else $error("occupancy above slot count");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> !pend_v_q)
		else $error("held result while idle");
	a_head_occ: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> recs[0].vld == (occ_q != '0))
		else $error("chain head disagrees with occupancy");
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> occ_q == $past(occ_q) + ptq_pkg::OCC_BITS'(1))
		else $error("add did not grow the list");
endmodule
`default_nettype wire
